FILE: design/efsq_pkg.sv
// ----------------------------------------------------------------------------
// efsq_pkg: shared types and constants for the earliest-free-server queue
// Window count, field widths, cell control and search word types, FSM states.
// ----------------------------------------------------------------------------
package efsq_pkg;

    localparam int MAX_WINDOWS = 16;
    localparam int WIN_W       = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_W       = $clog2(MAX_WINDOWS + 1);

    localparam int TIME_W  = 32;
    localparam int SEC_W   = 17;
    localparam int MIN_W   = 10;
    localparam int SVC_W   = 16;   // minutes * 60 fits in 16 bits
    localparam int SUM_W   = 48;
    localparam int NWIN_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam int SEC_PER_MIN = 60;

    localparam logic [SEC_W-1:0]  OPEN_RESET  = SEC_W'(8 * 3600);
    localparam logic [SEC_W-1:0]  CLOSE_RESET = SEC_W'(17 * 3600);
    localparam logic [NWIN_W-1:0] NWIN_RESET  = NWIN_W'(1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_WINDOWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_TIME   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_TIME  = CFG_IDX_W'(2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_CALC,
        S_EMIT
    } t_state;

    // search word travelling down the chain
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] best_time;
        logic [WIN_W-1:0]  best_idx;
    } t_token;

    // broadcast control to every cell
    typedef struct packed {
        logic              load;   // reload all free times
        logic              wr;     // write one free time
        logic [WIN_W-1:0]  idx;
        logic [TIME_W-1:0] value;
    } t_cell_ctl;

endpackage

FILE: design/efsq_cell.sv
// ----------------------------------------------------------------------------
// efsq_cell: one service window
// Holds the window free time and folds it into the passing min-search word.
// ----------------------------------------------------------------------------
module efsq_cell
    import efsq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [WIN_W-1:0] i_cell_idx,
    input  logic [CNT_W-1:0] i_count,
    input  t_cell_ctl        i_ctl,
    input  t_token           i_tok,
    output t_token           o_tok
);

    logic [TIME_W-1:0] r_free;
    logic              r_tok_valid;
    logic [TIME_W-1:0] r_tok_time;
    logic [WIN_W-1:0]  r_tok_idx;

    logic in_use;
    logic take;

    assign in_use = CNT_W'(i_cell_idx) < i_count;
    // strict less keeps the lower index on a tie
    assign take   = in_use && (r_free < i_tok.best_time);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= TIME_W'(OPEN_RESET);
        end else if (i_ctl.load) begin
            r_free <= i_ctl.value;
        end else if (i_ctl.wr && (i_ctl.idx == i_cell_idx)) begin
            r_free <= i_ctl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_time <= take ? r_free : i_tok.best_time;
        r_tok_idx  <= take ? i_cell_idx : i_tok.best_idx;
    end

    assign o_tok.valid     = r_tok_valid;
    assign o_tok.best_time = r_tok_time;
    assign o_tok.best_idx  = r_tok_idx;

endmodule

FILE: design/earliest_free_server_queue.sv
// ----------------------------------------------------------------------------
// earliest_free_server_queue: multi-window FIFO customer queue
// Sends each customer to the window that frees up first and keeps totals.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  -------------------------------
//  in       sink       i_in_valid / o_in_ready   arrival_seconds, service_minutes
//  out      source     o_out_valid / i_out_ready served, window_index, start,
//                                                wait, total_wait, served_count
//  cfg      sink       i_cfg_valid / o_cfg_ready cfg_index, cfg_data
//
//  Sequence: one input word at a time; a new word is taken only in idle. The
//  search word walks the full chain of window cells, one cell per cycle,
//  whatever the number of windows in use; then one step forms start and
//  wait, and one step updates the window, the totals and the output stage.
//  Reset: synchronous, active low; every free time returns to 8:00, totals
//  clear, registers take their reset values.
//  Stalls: the output stage holds one result; a new input word is taken
//  while it waits, and only the final update step waits for it to drain.
//  A config write to a known register reloads every free time with open_time.
// ----------------------------------------------------------------------------
module earliest_free_server_queue
    import efsq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SEC_W-1:0]      i_arrival_seconds,
    input  logic [MIN_W-1:0]      i_service_minutes,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_served,
    output logic [3:0]            o_window_index,
    output logic [TIME_W-1:0]     o_start_seconds,
    output logic [TIME_W-1:0]     o_wait_seconds,
    output logic [SUM_W-1:0]      o_total_wait,
    output logic [31:0]           o_served_count,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [NWIN_W-1:0] r_num_windows;
    logic [SEC_W-1:0]  r_open_time;
    logic [SEC_W-1:0]  r_close_time;
    logic              r_load;
    logic              cfg_wr;
    logic [CNT_W-1:0]  w_count;

    assign cfg_wr = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_windows <= NWIN_RESET;
            r_open_time   <= OPEN_RESET;
            r_close_time  <= CLOSE_RESET;
            r_load        <= 1'b0;
        end else begin
            r_load <= 1'b0;
            if (cfg_wr) begin
                case (i_cfg_index)
                    REG_NUM_WINDOWS: begin
                        r_num_windows <= i_cfg_data[NWIN_W-1:0];
                        r_load        <= 1'b1;
                    end
                    REG_OPEN_TIME: begin
                        r_open_time <= i_cfg_data[SEC_W-1:0];
                        r_load      <= 1'b1;
                    end
                    REG_CLOSE_TIME: begin
                        r_close_time <= i_cfg_data[SEC_W-1:0];
                        r_load       <= 1'b1;
                    end
                    default: begin
                        // unknown index: ignored
                    end
                endcase
            end
        end
    end

    // windows in use: zero means one, too many clamps to the chain length
    always_comb begin
        if (r_num_windows == '0) begin
            w_count = CNT_W'(1);
        end else if (32'(r_num_windows) > MAX_WINDOWS) begin
            w_count = CNT_W'(MAX_WINDOWS);
        end else begin
            w_count = CNT_W'(r_num_windows);
        end
    end

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;
    logic   in_acc;
    logic   emit_go;
    logic   r_launch;

    t_token w_tok [0:MAX_WINDOWS];
    t_token tail_tok;

    assign tail_tok = w_tok[MAX_WINDOWS];
    assign in_acc   = i_in_valid && o_in_ready;
    assign emit_go  = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cfg_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (tail_tok.valid) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (emit_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // customer datapath
    // ------------------------------------------------------------------
    logic [SEC_W-1:0]  r_arrival;
    logic [SVC_W-1:0]  r_svc_sec;
    logic              r_served;
    logic [TIME_W-1:0] r_best_time;
    logic [WIN_W-1:0]  r_best_idx;
    logic [TIME_W-1:0] r_start;
    logic [TIME_W-1:0] r_wait;
    logic [SUM_W-1:0]  r_wait_sum;
    logic [31:0]       r_served_total;

    logic [TIME_W-1:0] w_arr32;
    logic [TIME_W:0]   w_fin_wide;
    logic [TIME_W-1:0] w_finish;
    logic [SUM_W:0]    w_sum_wide;
    logic [SUM_W-1:0]  n_wait_sum;
    logic [31:0]       n_served_total;

    assign w_arr32    = TIME_W'(r_arrival);
    assign w_fin_wide = {1'b0, r_start} + (TIME_W + 1)'(r_svc_sec);
    assign w_finish   = w_fin_wide[TIME_W] ? '1 : w_fin_wide[TIME_W-1:0];
    assign w_sum_wide = {1'b0, r_wait_sum} + (SUM_W + 1)'(r_wait);

    always_comb begin
        n_wait_sum     = r_wait_sum;
        n_served_total = r_served_total;
        if (r_served) begin
            n_wait_sum = w_sum_wide[SUM_W] ? '1 : w_sum_wide[SUM_W-1:0];
            if (r_served_total != '1) begin
                n_served_total = r_served_total + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch <= 1'b0;
        end else begin
            r_launch <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_arrival <= i_arrival_seconds;
            r_svc_sec <= SVC_W'(32'(i_service_minutes) * SEC_PER_MIN);
            r_served  <= !(i_arrival_seconds > r_close_time);
        end
        if (r_state == S_SEARCH && tail_tok.valid) begin
            r_best_time <= tail_tok.best_time;
            r_best_idx  <= tail_tok.best_idx;
        end
        if (r_state == S_CALC) begin
            if (!r_served) begin
                r_start <= '0;
                r_wait  <= '0;
            end else if (w_arr32 > r_best_time) begin
                r_start <= w_arr32;
                r_wait  <= '0;
            end else begin
                r_start <= r_best_time;
                r_wait  <= r_best_time - w_arr32;
            end
        end
    end

    // running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_sum     <= '0;
            r_served_total <= '0;
        end else if (r_state == S_EMIT && emit_go) begin
            r_wait_sum     <= n_wait_sum;
            r_served_total <= n_served_total;
        end
    end

    // ------------------------------------------------------------------
    // output stage
    // ------------------------------------------------------------------
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && emit_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && emit_go) begin
            o_served        <= r_served;
            o_window_index  <= r_served ? 4'(r_best_idx) : 4'd0;
            o_start_seconds <= r_start;
            o_wait_seconds  <= r_wait;
            o_total_wait    <= n_wait_sum;
            o_served_count  <= n_served_total;
        end
    end

    assign o_out_valid = r_out_valid;

    // ------------------------------------------------------------------
    // chain of window cells
    // ------------------------------------------------------------------
    t_cell_ctl w_ctl;

    assign w_ctl.load  = r_load;
    assign w_ctl.wr    = (r_state == S_EMIT) && emit_go && r_served;
    assign w_ctl.idx   = r_best_idx;
    assign w_ctl.value = r_load ? TIME_W'(r_open_time) : w_finish;

    // search word enters with the largest time so window 0 always wins ties
    assign w_tok[0].valid     = r_launch;
    assign w_tok[0].best_time = '1;
    assign w_tok[0].best_idx  = '0;

    for (genvar g = 0; g < MAX_WINDOWS; g++) begin : g_cell
        efsq_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (WIN_W'(g)),
            .i_count    (w_count),
            .i_ctl      (w_ctl),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1])
        );
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_tail_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail_tok.valid |-> r_state == S_SEARCH)
        else $error("search word left chain outside search state");

    a_launch_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_launch && r_state == S_SEARCH)
        else $error("accepted word did not launch a search");

    a_write_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.wr |-> r_state == S_EMIT && !r_load)
        else $error("window write outside update step");

    a_unserved_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) && !o_served |->
            o_window_index == 4'd0 && o_start_seconds == '0 && o_wait_seconds == '0)
        else $error("unserved result carries nonzero fields");

    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) && o_served |-> o_served_count != '0)
        else $error("served result with zero served count");

endmodule

FILE: test/earliest_free_server_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_free_server_queue_test: self-checking bench for the window queue
// Feeds customer words through valid/ready with random gaps and stalls, keeps
// a behavioral copy of the window free times and totals, and compares every
// result word in order. Covers directed corner cases, random days under
// several configurations, and a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module earliest_free_server_queue_test
    import efsq_pkg::*;
;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 7;
    localparam int HOLD_CYCLES    = 400;      // long output hold-off
    localparam int WATCHDOG_LIMIT = 5000;     // cycles with no handshake at all
    localparam int SETTLE_CYCLES  = 2 * (MAX_WINDOWS + 4);
    localparam int REPORT_LIMIT   = 10;
    localparam int SEC_MAX        = (1 << SEC_W) - 1;
    localparam int MIN_MAX        = (1 << MIN_W) - 1;

    // index 3 is decoded by nobody; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

    // one result word, in port order
    typedef struct packed {
        logic              served;
        logic [3:0]        window_idx;
        logic [TIME_W-1:0] start_s;
        logic [TIME_W-1:0] wait_s;
        logic [SUM_W-1:0]  total_wait;
        logic [31:0]       served_cnt;
    } t_visit;

    typedef struct packed {
        logic [SEC_W-1:0] arrival;
        logic [MIN_W-1:0] minutes;
    } t_customer;

    // DUT ports, inputs all known from time zero
    logic                  i_clk             = 1'b0;
    logic                  i_rst_n           = 1'b0;
    logic                  i_in_valid        = 1'b0;
    logic                  o_in_ready;
    logic [SEC_W-1:0]      i_arrival_seconds = '0;
    logic [MIN_W-1:0]      i_service_minutes = '0;
    logic                  o_out_valid;
    logic                  i_out_ready       = 1'b0;
    logic                  o_served;
    logic [3:0]            o_window_index;
    logic [TIME_W-1:0]     o_start_seconds;
    logic [TIME_W-1:0]     o_wait_seconds;
    logic [SUM_W-1:0]      o_total_wait;
    logic [31:0]           o_served_count;
    logic                  i_cfg_valid       = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index       = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data        = '0;

    // behavioral copy of the block state
    logic [NWIN_W-1:0]     model_windows;
    logic [SEC_W-1:0]      model_open;
    logic [SEC_W-1:0]      model_close;
    logic [TIME_W-1:0]     free_at [MAX_WINDOWS];
    logic [SUM_W-1:0]      model_wait_sum;
    logic [31:0]           model_served;

    t_customer customer_q[$];   // customers waiting to be offered
    t_visit    visit_q[$];      // predicted results, oldest first

    int  send_idle_pct = 0;     // chance the sender sits out a cycle
    int  stall_pct     = 0;     // chance the receiver drops ready
    bit  hold_request  = 1'b0;  // asks the receiver for a long hold-off
    int  hold_left     = 0;
    int  bad_results   = 0;
    int  quiet_cycles  = 0;
    t_visit got_visit;
    t_visit want_visit;

    earliest_free_server_queue uut (.*);

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic void reload_free_times();
        foreach (free_at[w]) free_at[w] = TIME_W'(model_open);
    endfunction

    function automatic void reset_model();
        model_windows  = NWIN_RESET;
        model_open     = OPEN_RESET;
        model_close    = CLOSE_RESET;
        model_wait_sum = '0;
        model_served   = '0;
        reload_free_times();
    endfunction

    // any known register reloads all free times; totals survive
    function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_NUM_WINDOWS: model_windows = data[NWIN_W-1:0];
            REG_OPEN_TIME:   model_open    = data[SEC_W-1:0];
            REG_CLOSE_TIME:  model_close   = data[SEC_W-1:0];
            default:         return;
        endcase
        reload_free_times();
    endfunction

    // route one customer to the earliest free window, update state
    function automatic t_visit serve_customer(logic [SEC_W-1:0] arrival,
                                              logic [MIN_W-1:0] minutes);
        t_visit            v;
        int                in_use;
        int                best;
        logic [TIME_W-1:0] start_at;
        longint unsigned   done_at;
        longint unsigned   sum;
        v = '0;
        if (arrival > model_close) begin
            // turned away: totals only, nothing changes
            v.total_wait = model_wait_sum;
            v.served_cnt = model_served;
            return v;
        end
        // zero means one window, anything past the top saturates
        if (model_windows == '0)
            in_use = 1;
        else if (int'(model_windows) > MAX_WINDOWS)
            in_use = MAX_WINDOWS;
        else
            in_use = int'(model_windows);
        best = 0;
        for (int w = 1; w < in_use; w++) begin
            if (free_at[w] < free_at[best]) best = w;   // strict: lowest wins tie
        end
        start_at = free_at[best];
        if (TIME_W'(arrival) > start_at) start_at = TIME_W'(arrival);
        v.wait_s = start_at - TIME_W'(arrival);
        done_at  = longint'(start_at) + longint'(minutes) * longint'(SEC_PER_MIN);
        free_at[best] = (done_at > 64'hFFFF_FFFF) ? '1 : done_at[TIME_W-1:0];
        sum = longint'(model_wait_sum) + longint'(v.wait_s);
        model_wait_sum = (sum > 64'hFFFF_FFFF_FFFF) ? '1 : sum[SUM_W-1:0];
        if (model_served != '1) model_served = model_served + 32'd1;
        v.served     = 1'b1;
        v.window_idx = best[3:0];
        v.start_s    = start_at;
        v.total_wait = model_wait_sum;
        v.served_cnt = model_served;
        return v;
    endfunction

    function automatic string visit_text(t_visit v);
        return $sformatf("served=%0d window=%0d start=%0d wait=%0d total=%0d count=%0d",
                         v.served, v.window_idx, v.start_s, v.wait_s,
                         v.total_wait, v.served_cnt);
    endfunction

    // ------------------------------------------------------------------------
    // Input side: offers queued customers, predicts on each accepted word.
    // Valid is only decided again once the current word is taken, so one
    // nonblocking write per edge and the payload never moves under valid.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            visit_q.push_back(serve_customer(i_arrival_seconds, i_service_minutes));
            void'(customer_q.pop_front());
        end
        if (!i_in_valid || o_in_ready) begin
            if (i_rst_n && customer_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid        <= 1'b1;
                i_arrival_seconds <= customer_q[0].arrival;
                i_service_minutes <= customer_q[0].minutes;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output side: checks each taken word against the oldest prediction and
    // drives ready, including the long hold-off on request.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_visit = {o_served, o_window_index, o_start_seconds,
                         o_wait_seconds, o_total_wait, o_served_count};
            if (visit_q.size() == 0) begin
                bad_results++;
                if (bad_results <= REPORT_LIMIT)
                    $display("%0t: result word with nothing pending: %s",
                             $realtime, visit_text(got_visit));
            end else begin
                want_visit = visit_q.pop_front();
                if (got_visit !== want_visit) begin
                    bad_results++;
                    if (bad_results <= REPORT_LIMIT) begin
                        $display("%0t: result word differs", $realtime);
                        $display("  expected %s", visit_text(want_visit));
                        $display("  actual   %s", visit_text(got_visit));
                    end
                end
            end
        end
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog: any handshake on any channel resets the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no handshake for %0d cycles", $realtime, quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Shared tasks
    // ------------------------------------------------------------------------

    task automatic wait_until_drained();
        while (customer_q.size() != 0 || visit_q.size() != 0) @(posedge i_clk);
    endtask

    // queue a customer; keep at most two waiting so the sender stays busy
    task automatic send_customer(int unsigned arrival, int unsigned minutes);
        t_customer c;
        c.arrival = arrival[SEC_W-1:0];
        c.minutes = minutes[MIN_W-1:0];
        while (customer_q.size() >= 2) @(posedge i_clk);
        customer_q.push_back(c);
    endtask

    // registers change only with the block idle
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, int unsigned data);
        wait_until_drained();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_setting(idx, data[CFG_DATA_W-1:0]);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // one window, 8:00 to 17:00 as out of reset
    task automatic test_reset_defaults();
        send_customer(0, 0);             // early bird waits for opening
        send_customer(0, MIN_MAX);       // longest service
        send_customer(28800, 1);         // queued behind it
        send_customer(61200, 0);         // exactly at closing: still served
        send_customer(61201, 5);         // one second late
        send_customer(86399, 0);         // end of day
        send_customer(SEC_MAX, MIN_MAX); // field maximum, turned away
        send_customer(30000, 2);         // out of order, judged alone
    endtask

    task automatic test_window_selection();
        write_register(REG_NUM_WINDOWS, MAX_WINDOWS);
        for (int k = 0; k < 4; k++) send_customer(100, 10);   // ties: 0,1,2,3
        write_register(REG_UNUSED, SEC_MAX);                  // must not reload
        send_customer(200, 0);                                // lands on window 4
        write_register(REG_NUM_WINDOWS, 0);                   // acts as one
        send_customer(28800, 3);
        send_customer(28800, 0);
        write_register(REG_NUM_WINDOWS, 31);                  // saturates
        send_customer(40000, 1);
        send_customer(40000, 1);
        write_register(REG_NUM_WINDOWS, MAX_WINDOWS + 1);
        send_customer(40000, 0);
    endtask

    task automatic test_config_extremes();
        write_register(REG_NUM_WINDOWS, 2);
        write_register(REG_OPEN_TIME, 0);
        write_register(REG_CLOSE_TIME, 0);
        send_customer(0, 0);
        send_customer(1, 1);             // past a midnight close
        send_customer(0, MIN_MAX);
        write_register(REG_OPEN_TIME, SEC_MAX);
        write_register(REG_CLOSE_TIME, SEC_MAX);
        send_customer(SEC_MAX, MIN_MAX);
        send_customer(0, 0);             // long wait for a late opening
        write_register(REG_OPEN_TIME, 86399);
        write_register(REG_CLOSE_TIME, 86399);
        send_customer(86399, 512);
    endtask

    // random days: new settings, then a mostly ordered stream of arrivals
    task automatic test_random_days(int days, int per_day);
        int unsigned nwin, open_s, close_s, clock_s, in_use, arrival, minutes;
        for (int d = 0; d < days; d++) begin
            nwin    = ($urandom_range(9) == 0) ? $urandom_range(31)
                                               : $urandom_range(MAX_WINDOWS, 1);
            open_s  = ($urandom_range(9) == 0) ? $urandom_range(SEC_MAX)
                                               : $urandom_range(36000, 21600);
            close_s = ($urandom_range(7) == 0) ? $urandom_range(SEC_MAX)
                                               : open_s + $urandom_range(36000, 3600);
            if (close_s > SEC_MAX) close_s = SEC_MAX;
            write_register(REG_NUM_WINDOWS, nwin);
            write_register(REG_OPEN_TIME, open_s);
            write_register(REG_CLOSE_TIME, close_s);
            if ($urandom_range(3) == 0) write_register(REG_UNUSED, $urandom);
            in_use  = (nwin == 0) ? 1 : (nwin > MAX_WINDOWS) ? MAX_WINDOWS : nwin;
            clock_s = open_s - ((open_s < 1800) ? open_s : $urandom_range(1800));
            for (int k = 0; k < per_day; k++) begin
                // about one in twenty is a stray arrival anywhere in the field
                if ($urandom_range(19) == 0) begin
                    arrival = $urandom_range(SEC_MAX);
                end else begin
                    // step sized so the load stays above one: queues build
                    clock_s += $urandom_range(1200 / in_use);
                    if (clock_s > SEC_MAX) clock_s = SEC_MAX;
                    arrival = clock_s;
                end
                minutes = ($urandom_range(9) == 0) ? $urandom_range(MIN_MAX)
                                                   : $urandom_range(20);
                send_customer(arrival, minutes);
            end
        end
    endtask

    // receiver goes deaf while words keep coming: the block must stall input
    task automatic test_output_backpressure();
        write_register(REG_NUM_WINDOWS, 3);
        write_register(REG_OPEN_TIME, 0);
        write_register(REG_CLOSE_TIME, SEC_MAX);
        hold_request = 1'b1;
        for (int k = 0; k < 12; k++) send_customer(k * 30, $urandom_range(5, 1));
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_model();
        send_idle_pct = 20;
        stall_pct     = 56;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_window_selection();
        test_config_extremes();
        test_random_days(5, 53);

        send_idle_pct = 56;
        stall_pct     = 20;
        test_random_days(5, 53);

        send_idle_pct = 0;
        stall_pct     = 0;
        test_random_days(5, 53);
        test_output_backpressure();

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (bad_results == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
